>>> sv/mcpc_pkg.sv
// ----------------------------------------------------------------------------
// mcpc_pkg
// Shared widths, constants and types of the microphone channel power check.
// ----------------------------------------------------------------------------
package mcpc_pkg;

  // sample and square
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 31;

  // power measurement
  localparam int WACC_W   = 47;
  localparam int POWER_W  = 55;
  localparam int PROD_W   = 62;
  localparam int CHAN_W   = 6;
  localparam int PCNT_W   = 6;
  localparam int MASK_W   = 35;
  localparam int LEVEL_W  = 4;

  // configuration registers
  localparam int WS_W       = 16;
  localparam int WPP_W      = 8;
  localparam int SHIFT_W    = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SAMPLES    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOWS_PER_PHASE = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_SHIFT      = 2'd2;

  localparam logic [WS_W-1:0]    RST_WINDOW_SAMPLES    = 16'd4800;
  localparam logic [WPP_W-1:0]   RST_WINDOWS_PER_PHASE = 8'd20;
  localparam logic [SHIFT_W-1:0] RST_WINDOW_SHIFT      = 6'd30;

  // pass criterion: HIGH_RATIO * high >= LOW_RATIO * low
  localparam logic [6:0] HIGH_RATIO = 7'd100;
  localparam logic [6:0] LOW_RATIO  = 7'd105;

  // pipeline depth: input, square, window, shift, power, products, output
  localparam int STAGES = 7;

  // output stream packing
  localparam int OUT_PAD_W   = 5;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 2;

  // per-item control carried along the power path
  typedef struct packed {
    logic              phase;
    logic [CHAN_W-1:0] channel;
    logic              win_end;
    logic              verdict;
    logic              done;
  } pwr_evt_t;

endpackage

>>> sv/mic_channel_power_check.sv
// ----------------------------------------------------------------------------
// mic_channel_power_check
// Microphone channel power test with level meter, streaming in and out.
// ----------------------------------------------------------------------------
// Takes one signed sample per clock unless the input is held, and returns
// one result per sample through a seven-register pipeline (input, square,
// window sum, window shift, phase power, ratio products, output). Each stage
// only holds while the stage after it is full and held, so back-pressure on
// the output fills empty stages before the input stalls. Bit 0 of out_tdata
// gives the phase in which the sample was taken, tone on (0) or muted (1);
// when it changes, outside logic should switch the tone for the samples that
// follow. The user must write configuration only while no results are
// pending; the block itself does not enforce it. A write takes effect for
// the next sample.
// ----------------------------------------------------------------------------
module mic_channel_power_check #(
  parameter int NUM_CHANNELS  = 35,
  parameter int METER_SAMPLES = 32,
  parameter int LED_COUNT     = 10,
  parameter int METER_SHIFT   = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mcpc_pkg::SAMPLE_W-1:0]    in_tdata,   // sample
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // phase, channel, meter_level, channel_ok, power_high_out, power_low_out,
  // ok_count, ok_mask, zero fill
  output logic [mcpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [mcpc_pkg::OUT_TUSER_W-1:0] out_tuser,  // meter_valid, verdict_valid
  output logic                             out_tlast,  // sequence_done
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [mcpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mcpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mcpc_pkg::*;

  // configuration registers
  logic [WS_W-1:0]    window_samples_r;
  logic [WPP_W-1:0]   windows_per_phase_r;
  logic [SHIFT_W-1:0] window_shift_r;

  // pipeline control
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] en;
  logic [STAGES-1:0] take;

  // datapath
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [MAG_W-1:0]   mag_nxt;
  logic [MAG_W-1:0]   mag_r;
  logic [2*MAG_W-1:0] sq_full;
  logic [SQ_W-1:0]    sq_r;
  logic               mv3;
  logic [LEVEL_W-1:0] ml3;
  logic               mv4_r;
  logic [LEVEL_W-1:0] ml4_r;
  logic               mv5_r;
  logic [LEVEL_W-1:0] ml5_r;
  logic               mv6_r;
  logic [LEVEL_W-1:0] ml6_r;

  pwr_evt_t           evt5;
  logic [POWER_W-1:0] ph5;
  logic [POWER_W-1:0] pl5;
  logic [PROD_W-1:0]  phi5;
  logic [PROD_W-1:0]  plo5;

  logic               res_phase;
  logic [CHAN_W-1:0]  res_channel;
  logic               res_verdict;
  logic               res_ok;
  logic [POWER_W-1:0] res_ph;
  logic [POWER_W-1:0] res_pl;
  logic [PCNT_W-1:0]  res_count;
  logic [MASK_W-1:0]  res_mask;
  logic               res_done;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_samples_r    <= RST_WINDOW_SAMPLES;
      windows_per_phase_r <= RST_WINDOWS_PER_PHASE;
      window_shift_r      <= RST_WINDOW_SHIFT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_WINDOW_SAMPLES:    window_samples_r    <= cfg_wdata[WS_W-1:0];
        CFG_WINDOWS_PER_PHASE: windows_per_phase_r <= cfg_wdata[WPP_W-1:0];
        CFG_WINDOW_SHIFT:      window_shift_r      <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign take    = en & {vld_r[STAGES-2:0], in_tvalid};
  assign vld_nxt = (en & {vld_r[STAGES-2:0], in_tvalid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[STAGES-1];

  // input register
  always_ff @(posedge clk) begin
    if (take[0]) begin
      sample_r <= in_tdata;
    end
  end

  // magnitude and square
  assign mag_nxt = sample_r[SAMPLE_W-1] ? MAG_W'(-sample_r) : MAG_W'(sample_r);
  assign sq_full = mag_nxt * mag_nxt;

  always_ff @(posedge clk) begin
    if (take[1]) begin
      mag_r <= mag_nxt;
      sq_r  <= sq_full[SQ_W-1:0];
    end
  end

  mcpc_meter #(
    .METER_SAMPLES (METER_SAMPLES),
    .LED_COUNT     (LED_COUNT),
    .METER_SHIFT   (METER_SHIFT)
  ) u_meter (
    .clk         (clk),
    .rst_n       (rst_n),
    .take_sum    (take[2]),
    .take_lvl    (take[3]),
    .mag         (mag_r),
    .meter_valid (mv3),
    .meter_level (ml3)
  );

  // meter result carried to the output register
  always_ff @(posedge clk) begin
    if (take[4]) begin
      mv4_r <= mv3;
      ml4_r <= ml3;
    end
    if (take[5]) begin
      mv5_r <= mv4_r;
      ml5_r <= ml4_r;
    end
    if (take[6]) begin
      mv6_r <= mv5_r;
      ml6_r <= ml5_r;
    end
  end

  mcpc_power #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_power (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .take_win              (take[2]),
    .take_shf              (take[3]),
    .take_acc              (take[4]),
    .take_prd              (take[5]),
    .sq                    (sq_r),
    .cfg_window_samples    (window_samples_r),
    .cfg_windows_per_phase (windows_per_phase_r),
    .cfg_window_shift      (window_shift_r),
    .evt                   (evt5),
    .power_high            (ph5),
    .power_low             (pl5),
    .prod_high             (phi5),
    .prod_low              (plo5)
  );

  mcpc_verdict u_verdict (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take[6]),
    .evt            (evt5),
    .power_high     (ph5),
    .power_low      (pl5),
    .prod_high      (phi5),
    .prod_low       (plo5),
    .phase          (res_phase),
    .channel        (res_channel),
    .verdict_valid  (res_verdict),
    .channel_ok     (res_ok),
    .power_high_out (res_ph),
    .power_low_out  (res_pl),
    .ok_count       (res_count),
    .ok_mask        (res_mask),
    .sequence_done  (res_done)
  );

  // result packing
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_mask, res_count, res_pl, res_ph,
                      res_ok, ml6_r, res_channel, res_phase};
  assign out_tuser = {res_verdict, mv6_r};
  assign out_tlast = res_done;

`ifndef SYNTH
  // an empty output register never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // sequence end only comes with a channel verdict
  a_done_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[1])
    else $error("sequence end without verdict");

  // pass flag and powers only on a verdict
  a_ok_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (!res_ok && res_ph == '0 && res_pl == '0))
    else $error("verdict fields set without verdict");

  // led count is zero between meter blocks
  a_level_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (ml6_r == '0))
    else $error("meter level set without meter transfer");
`endif

endmodule

>>> sv/mcpc_meter.sv
// ----------------------------------------------------------------------------
// mcpc_meter
// Level meter: sums sample magnitudes over a block and scales to an LED count.
// ----------------------------------------------------------------------------
module mcpc_meter #(
  parameter int METER_SAMPLES = 32,
  parameter int LED_COUNT     = 10,
  parameter int METER_SHIFT   = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take_sum,
  input  logic                         take_lvl,
  input  logic [mcpc_pkg::MAG_W-1:0]   mag,
  output logic                         meter_valid,
  output logic [mcpc_pkg::LEVEL_W-1:0] meter_level
);
  import mcpc_pkg::*;

  localparam int CW = (METER_SAMPLES > 1) ? $clog2(METER_SAMPLES) : 1;
  localparam int SW = MAG_W + CW;
  localparam int PW = SW + 6;
  localparam logic [CW:0]   LIMIT   = (CW+1)'(METER_SAMPLES);
  localparam logic [PW-1:0] LED_MUL = PW'(LED_COUNT);

  logic [SW-1:0]      sum_r;
  logic [CW-1:0]      cnt_r;
  logic [CW:0]        cnt_inc;
  logic [SW-1:0]      sum_inc;
  logic               blk_end;
  logic               blk_r;
  logic [SW-1:0]      bsum_r;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      lv;
  logic [PW-1:0]      lv_sat;
  logic               meter_valid_r;
  logic [LEVEL_W-1:0] meter_level_r;
  logic [LEVEL_W-1:0] meter_level_nxt;

  // block accumulation
  assign cnt_inc = {1'b0, cnt_r} + (CW+1)'(1);
  assign sum_inc = sum_r + SW'(mag);
  assign blk_end = (cnt_inc >= LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (take_sum) begin
      sum_r <= blk_end ? '0 : sum_inc;
      cnt_r <= blk_end ? '0 : cnt_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (take_sum) begin
      blk_r  <= blk_end;
      bsum_r <= sum_inc;
    end
  end

  // scale to leds, saturate, keep four bits
  assign prod   = LED_MUL * PW'(bsum_r);
  assign lv     = prod >> METER_SHIFT;
  assign lv_sat = (lv > LED_MUL) ? LED_MUL : lv;
  assign meter_level_nxt = blk_r ? lv_sat[LEVEL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (take_lvl) begin
      meter_valid_r <= blk_r;
      meter_level_r <= meter_level_nxt;
    end
  end

  assign meter_valid = meter_valid_r;
  assign meter_level = meter_level_r;

endmodule

>>> sv/mcpc_power.sv
// ----------------------------------------------------------------------------
// mcpc_power
// Window and phase sequencing, window sum shift, phase power accumulation
// and the ratio products for the pass test.
// ----------------------------------------------------------------------------
module mcpc_power #(
  parameter int NUM_CHANNELS = 35
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take_win,
  input  logic                         take_shf,
  input  logic                         take_acc,
  input  logic                         take_prd,
  input  logic [mcpc_pkg::SQ_W-1:0]    sq,
  input  logic [mcpc_pkg::WS_W-1:0]    cfg_window_samples,
  input  logic [mcpc_pkg::WPP_W-1:0]   cfg_windows_per_phase,
  input  logic [mcpc_pkg::SHIFT_W-1:0] cfg_window_shift,
  output mcpc_pkg::pwr_evt_t           evt,
  output logic [mcpc_pkg::POWER_W-1:0] power_high,
  output logic [mcpc_pkg::POWER_W-1:0] power_low,
  output logic [mcpc_pkg::PROD_W-1:0]  prod_high,
  output logic [mcpc_pkg::PROD_W-1:0]  prod_low
);
  import mcpc_pkg::*;

  localparam logic [CHAN_W:0] LAST_CHAN = (CHAN_W+1)'(NUM_CHANNELS);

  // window stage
  logic [WACC_W-1:0] win_acc_r;
  logic [WS_W-1:0]   smp_cnt_r;
  logic [WPP_W-1:0]  win_cnt_r;
  logic              phase_r;
  logic [CHAN_W-1:0] chan_r;
  logic [WS_W:0]     limit_s;
  logic [WPP_W:0]    limit_w;
  logic [WS_W:0]     smp_inc;
  logic [WPP_W:0]    win_inc;
  logic [CHAN_W:0]   chan_inc;
  logic [WACC_W-1:0] acc_sum;
  logic              w_end;
  logic              ph_end;
  pwr_evt_t          evt_nxt;
  pwr_evt_t          evt2_r;
  logic [WACC_W-1:0] wsum2_r;

  // shift stage
  pwr_evt_t          evt3_r;
  logic [WACC_W-1:0] wp3_r;

  // power stage
  logic [POWER_W-1:0] ph_acc_r;
  logic [POWER_W-1:0] pl_acc_r;
  logic [POWER_W-1:0] ph_acc_nxt;
  logic [POWER_W-1:0] pl_acc_nxt;
  pwr_evt_t           evt4_r;
  logic [POWER_W-1:0] ph4_r;
  logic [POWER_W-1:0] pl4_r;

  // product stage
  pwr_evt_t           evt5_r;
  logic [POWER_W-1:0] ph5_r;
  logic [POWER_W-1:0] pl5_r;
  logic [PROD_W-1:0]  phi5_r;
  logic [PROD_W-1:0]  plo5_r;

  // window and phase sequencing; a zero limit means the full count range
  assign limit_s  = {(cfg_window_samples == '0), cfg_window_samples};
  assign limit_w  = {(cfg_windows_per_phase == '0), cfg_windows_per_phase};
  assign smp_inc  = {1'b0, smp_cnt_r} + (WS_W+1)'(1);
  assign win_inc  = {1'b0, win_cnt_r} + (WPP_W+1)'(1);
  assign chan_inc = {1'b0, chan_r} + (CHAN_W+1)'(1);
  assign acc_sum  = win_acc_r + WACC_W'(sq);
  assign w_end    = (smp_inc >= limit_s);
  assign ph_end   = w_end && (win_inc >= limit_w);

  always_comb begin
    evt_nxt.phase   = phase_r;
    evt_nxt.channel = chan_r;
    evt_nxt.win_end = w_end;
    evt_nxt.verdict = ph_end && phase_r;
    evt_nxt.done    = ph_end && phase_r && (chan_inc >= LAST_CHAN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_acc_r <= '0;
      smp_cnt_r <= '0;
      win_cnt_r <= '0;
      phase_r   <= 1'b0;
      chan_r    <= '0;
    end else if (take_win) begin
      win_acc_r <= w_end ? '0 : acc_sum;
      smp_cnt_r <= w_end ? '0 : smp_inc[WS_W-1:0];
      if (w_end) begin
        win_cnt_r <= ph_end ? '0 : win_inc[WPP_W-1:0];
      end
      if (ph_end) begin
        phase_r <= ~phase_r;
      end
      if (evt_nxt.verdict) begin
        chan_r <= evt_nxt.done ? '0 : chan_inc[CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_win) begin
      evt2_r  <= evt_nxt;
      wsum2_r <= acc_sum;
    end
  end

  // window power
  always_ff @(posedge clk) begin
    if (take_shf) begin
      evt3_r <= evt2_r;
      wp3_r  <= wsum2_r >> cfg_window_shift;
    end
  end

  // phase power accumulation, cleared after each verdict
  always_comb begin
    ph_acc_nxt = ph_acc_r;
    pl_acc_nxt = pl_acc_r;
    if (evt3_r.win_end) begin
      if (evt3_r.phase) begin
        pl_acc_nxt = pl_acc_r + POWER_W'(wp3_r);
      end else begin
        ph_acc_nxt = ph_acc_r + POWER_W'(wp3_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_acc_r <= '0;
      pl_acc_r <= '0;
    end else if (take_acc) begin
      ph_acc_r <= evt3_r.verdict ? '0 : ph_acc_nxt;
      pl_acc_r <= evt3_r.verdict ? '0 : pl_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_acc) begin
      evt4_r <= evt3_r;
      ph4_r  <= evt3_r.verdict ? ph_acc_nxt : '0;
      pl4_r  <= evt3_r.verdict ? pl_acc_nxt : '0;
    end
  end

  // ratio products for the pass test
  always_ff @(posedge clk) begin
    if (take_prd) begin
      evt5_r <= evt4_r;
      ph5_r  <= ph4_r;
      pl5_r  <= pl4_r;
      phi5_r <= PROD_W'(ph4_r) * PROD_W'(HIGH_RATIO);
      plo5_r <= PROD_W'(pl4_r) * PROD_W'(LOW_RATIO);
    end
  end

  assign evt        = evt5_r;
  assign power_high = ph5_r;
  assign power_low  = pl5_r;
  assign prod_high  = phi5_r;
  assign prod_low   = plo5_r;

endmodule

>>> sv/mcpc_verdict.sv
// ----------------------------------------------------------------------------
// mcpc_verdict
// Pass decision, pass count and pass mask; holds the result fields of the
// power path in the output register.
// ----------------------------------------------------------------------------
module mcpc_verdict (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  mcpc_pkg::pwr_evt_t           evt,
  input  logic [mcpc_pkg::POWER_W-1:0] power_high,
  input  logic [mcpc_pkg::POWER_W-1:0] power_low,
  input  logic [mcpc_pkg::PROD_W-1:0]  prod_high,
  input  logic [mcpc_pkg::PROD_W-1:0]  prod_low,
  output logic                         phase,
  output logic [mcpc_pkg::CHAN_W-1:0]  channel,
  output logic                         verdict_valid,
  output logic                         channel_ok,
  output logic [mcpc_pkg::POWER_W-1:0] power_high_out,
  output logic [mcpc_pkg::POWER_W-1:0] power_low_out,
  output logic [mcpc_pkg::PCNT_W-1:0]  ok_count,
  output logic [mcpc_pkg::MASK_W-1:0]  ok_mask,
  output logic                         sequence_done
);
  import mcpc_pkg::*;

  logic [PCNT_W-1:0]  pcnt_r;
  logic [MASK_W-1:0]  pmask_r;
  logic               ok;
  logic [PCNT_W-1:0]  pcnt_nxt;
  logic [MASK_W-1:0]  pmask_nxt;

  logic               phase_r;
  logic [CHAN_W-1:0]  channel_r;
  logic               verdict_r;
  logic               ok_r;
  logic [POWER_W-1:0] ph_r;
  logic [POWER_W-1:0] pl_r;
  logic [PCNT_W-1:0]  cnt_out_r;
  logic [MASK_W-1:0]  mask_out_r;
  logic               done_r;

  // pass test and running tallies; channels past the mask width drop out
  assign ok        = evt.verdict && (prod_high >= prod_low);
  assign pcnt_nxt  = ok ? pcnt_r + PCNT_W'(1) : pcnt_r;
  assign pmask_nxt = ok ? (pmask_r | (MASK_W'(1) << evt.channel)) : pmask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r  <= '0;
      pmask_r <= '0;
    end else if (take) begin
      pcnt_r  <= evt.done ? '0 : pcnt_nxt;
      pmask_r <= evt.done ? '0 : pmask_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (take) begin
      phase_r    <= evt.phase;
      channel_r  <= evt.channel;
      verdict_r  <= evt.verdict;
      ok_r       <= ok;
      ph_r       <= power_high;
      pl_r       <= power_low;
      cnt_out_r  <= pcnt_nxt;
      mask_out_r <= pmask_nxt;
      done_r     <= evt.done;
    end
  end

  assign phase          = phase_r;
  assign channel        = channel_r;
  assign verdict_valid  = verdict_r;
  assign channel_ok     = ok_r;
  assign power_high_out = ph_r;
  assign power_low_out  = pl_r;
  assign ok_count       = cnt_out_r;
  assign ok_mask        = mask_out_r;
  assign sequence_done  = done_r;

endmodule

>>> verif/mcpc_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpc_result_checker
// Watches the sample, result and register ports of the microphone channel
// power check, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
// Each sample transfer runs through a local model of the level meter, the
// window and phase power sums and the channel bookkeeping; the expected
// result is queued and matched against the oldest result transfer.
// ----------------------------------------------------------------------------
module mcpc_result_checker #(
  parameter int NUM_CHANNELS  = 35,
  parameter int METER_SAMPLES = 32,
  parameter int LED_COUNT     = 10,
  parameter int METER_SHIFT   = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [mcpc_pkg::SAMPLE_W-1:0]    in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [mcpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [mcpc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                             out_tlast,
  input  logic                             cfg_wr_en,
  input  logic [mcpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mcpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               mismatch_count,
  output int                               results_outstanding
);
  import mcpc_pkg::*;

  // register values after reset
  localparam logic [WS_W-1:0]    WS_AT_RESET    = 16'd4800;
  localparam logic [WPP_W-1:0]   WPP_AT_RESET   = 8'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_AT_RESET = 6'd30;

  typedef struct packed {
    logic               phase;
    logic [CHAN_W-1:0]  channel;
    logic               meter_valid;
    logic [LEVEL_W-1:0] meter_level;
    logic               verdict_valid;
    logic               channel_ok;
    logic [POWER_W-1:0] power_high;
    logic [POWER_W-1:0] power_low;
    logic [PCNT_W-1:0]  ok_count;
    logic [MASK_W-1:0]  ok_mask;
    logic               seq_done;
  } power_result_t;

  power_result_t predicted_results[$];

  // configuration copy
  logic [WS_W-1:0]    win_len;
  logic [WPP_W-1:0]   wins_per_phase;
  logic [SHIFT_W-1:0] win_shift;

  // measurement state
  logic [63:0]        meter_sum;
  int                 meter_cnt;
  logic [WACC_W-1:0]  win_acc;
  int                 samp_cnt;
  int                 win_cnt;
  logic               tone_low;
  logic [POWER_W-1:0] pwr_hi;
  logic [POWER_W-1:0] pwr_lo;
  logic [CHAN_W-1:0]  chan;
  logic [PCNT_W-1:0]  pass_cnt;
  logic [MASK_W-1:0]  pass_mask;

  // advance the model by one sample and return the result it gives
  function automatic power_result_t predict_sample(logic [SAMPLE_W-1:0] raw);
    power_result_t r;
    logic [16:0]   mag;
    logic [63:0]   sq;
    logic [63:0]   lv;
    logic [63:0]   wp;
    int            lim_s;
    int            lim_w;
    r = '0;
    r.phase   = tone_low;
    r.channel = chan;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    sq  = 64'(mag) * 64'(mag);

    // level meter
    meter_sum = meter_sum + 64'(mag);
    meter_cnt++;
    if (meter_cnt >= METER_SAMPLES) begin
      lv = (64'(LED_COUNT) * meter_sum) >> METER_SHIFT;
      if (lv > 64'(LED_COUNT)) lv = 64'(LED_COUNT);
      r.meter_valid = 1'b1;
      r.meter_level = lv[3:0];
      meter_sum = '0;
      meter_cnt = 0;
    end

    // window and phase power
    lim_s = (win_len == '0) ? 65536 : int'(win_len);
    lim_w = (wins_per_phase == '0) ? 256 : int'(wins_per_phase);
    win_acc = win_acc + sq[WACC_W-1:0];
    samp_cnt++;
    if (samp_cnt >= lim_s) begin
      wp = 64'(win_acc) >> win_shift;
      if (tone_low) pwr_lo = pwr_lo + wp[POWER_W-1:0];
      else pwr_hi = pwr_hi + wp[POWER_W-1:0];
      win_acc  = '0;
      samp_cnt = 0;
      win_cnt++;
      if (win_cnt >= lim_w) begin
        win_cnt = 0;
        if (!tone_low) begin
          tone_low = 1'b1;
        end else begin
          // channel verdict at the end of the muted phase
          tone_low        = 1'b0;
          r.verdict_valid = 1'b1;
          r.power_high    = pwr_hi;
          r.power_low     = pwr_lo;
          r.channel_ok    = (64'(pwr_hi) * 64'd100) >= (64'(pwr_lo) * 64'd105);
          if (r.channel_ok) begin
            pass_cnt++;
            if (int'(chan) < MASK_W) pass_mask[chan] = 1'b1;
          end
          pwr_hi = '0;
          pwr_lo = '0;
          if (int'(chan) + 1 >= NUM_CHANNELS) r.seq_done = 1'b1;
          else chan++;
        end
      end
    end
    r.ok_count = pass_cnt;
    r.ok_mask  = pass_mask;

    // sequence restarts from the first channel
    if (r.seq_done) begin
      chan      = '0;
      pass_cnt  = '0;
      pass_mask = '0;
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    power_result_t want;
    if (!rst_n) begin
      predicted_results.delete();
      mismatch_count = 0;
      win_len        = WS_AT_RESET;
      wins_per_phase = WPP_AT_RESET;
      win_shift      = SHIFT_AT_RESET;
      meter_sum = '0;
      meter_cnt = 0;
      win_acc   = '0;
      samp_cnt  = 0;
      win_cnt   = 0;
      tone_low  = 1'b0;
      pwr_hi    = '0;
      pwr_lo    = '0;
      chan      = '0;
      pass_cnt  = '0;
      pass_mask = '0;
    end else begin
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          $error("result transfer with no sample waiting for it");
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("phase",          64'(want.phase),         64'(out_tdata[0]));
          check_field("channel",        64'(want.channel),       64'(out_tdata[6:1]));
          check_field("meter_level",    64'(want.meter_level),   64'(out_tdata[10:7]));
          check_field("channel_ok",     64'(want.channel_ok),    64'(out_tdata[11]));
          check_field("power_high_out", 64'(want.power_high),    64'(out_tdata[66:12]));
          check_field("power_low_out",  64'(want.power_low),     64'(out_tdata[121:67]));
          check_field("ok_count",       64'(want.ok_count),      64'(out_tdata[127:122]));
          check_field("ok_mask",        64'(want.ok_mask),       64'(out_tdata[162:128]));
          check_field("zero fill",      64'(0),                  64'(out_tdata[167:163]));
          check_field("meter_valid",    64'(want.meter_valid),   64'(out_tuser[0]));
          check_field("verdict_valid",  64'(want.verdict_valid), 64'(out_tuser[1]));
          check_field("sequence_done",  64'(want.seq_done),      64'(out_tlast));
        end
      end

      // register writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_WINDOW_SAMPLES:    win_len        = cfg_wdata[WS_W-1:0];
          CFG_WINDOWS_PER_PHASE: wins_per_phase = cfg_wdata[WPP_W-1:0];
          CFG_WINDOW_SHIFT:      win_shift      = cfg_wdata[SHIFT_W-1:0];
          default: ;
        endcase
      end

      // sample transfer
      if (in_tvalid && in_tready) predicted_results.push_back(predict_sample(in_tdata));
    end
    results_outstanding = predicted_results.size();
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the microphone channel power check.
// ----------------------------------------------------------------------------
// A directed opening covers sample extremes, register extremes, shortening a
// window mid-way and the exact pass boundary; random phases then run whole
// channel sequences with loud tone-on and quiet tone-off samples, plus noise,
// under random gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import mcpc_pkg::*;

  localparam int RUN_LIMIT = 500_000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [SAMPLE_W-1:0]    in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  int                     mismatch_count;
  int                     results_outstanding;

  always #6 clk = ~clk;

  mic_channel_power_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  mcpc_result_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .out_tlast           (out_tlast),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  // run limit
  int cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side stalls, with calm stretches of no stalling
  int stall_left = 0;
  int calm_left  = 0;
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 2) begin
      calm_left = $urandom_range(40, 160);
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_tready <= 1'b0;
    end
  end

  // rough view of where the block is in its window and phase, used only
  // to shape the tone-on and tone-off loudness
  logic [WS_W-1:0]  cur_ws   = RST_WINDOW_SAMPLES;
  logic [WPP_W-1:0] cur_wpp  = RST_WINDOWS_PER_PHASE;
  int               s_cnt    = 0;
  int               w_cnt    = 0;
  logic             tone_low = 1'b0;
  int               amp_hi   = 20000;
  int               amp_lo   = 2000;
  logic             steady   = 1'b0;

  // loudness of the next channel: mostly passing, some failing, some even
  task automatic pick_levels();
    int r;
    r = $urandom_range(0, 99);
    amp_hi = $urandom_range(4000, 32768);
    if (r < 55) begin
      amp_lo = $urandom_range(0, amp_hi / 2);
    end else if (r < 80) begin
      amp_lo = amp_hi;
      amp_hi = $urandom_range(0, amp_lo / 2);
    end else begin
      amp_lo = amp_hi;
    end
  endtask

  task automatic advance_tone();
    int lim_s;
    int lim_w;
    lim_s = (cur_ws == '0) ? 65536 : int'(cur_ws);
    lim_w = (cur_wpp == '0) ? 256 : int'(cur_wpp);
    s_cnt++;
    if (s_cnt >= lim_s) begin
      s_cnt = 0;
      w_cnt++;
      if (w_cnt >= lim_w) begin
        w_cnt    = 0;
        tone_low = !tone_low;
        if (!tone_low) pick_levels();
      end
    end
  endtask

  function automatic logic [SAMPLE_W-1:0] draw_sample(int amp);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'h8000;
    if (r < 6) return 16'h7FFF;
    v = int'($urandom_range(0, 2 * amp)) - amp;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // one sample transfer, after an optional gap
  task automatic send_sample(logic [SAMPLE_W-1:0] s);
    int gap;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    advance_tone();
  endtask

  // hold the input until every predicted result has come out
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_outstanding != 0) @(negedge clk);
    repeat (STAGES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (addr)
      CFG_WINDOW_SAMPLES:    cur_ws  = data[WS_W-1:0];
      CFG_WINDOWS_PER_PHASE: cur_wpp = data[WPP_W-1:0];
      default: ;
    endcase
  endtask

  initial begin
    int                  n_items;
    int                  burst_left;
    int                  r;
    logic [SAMPLE_W-1:0] s;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    pick_levels();

    // sample extremes and alternating bit patterns at the reset settings
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h5555);
    send_sample(16'hAAAA);

    // largest register values
    drain();
    write_reg(CFG_WINDOW_SAMPLES, 16'd65535);
    write_reg(CFG_WINDOWS_PER_PHASE, 16'd255);
    write_reg(CFG_WINDOW_SHIFT, 16'd63);
    send_sample(16'h8000);
    send_sample(16'h7FFF);

    // zero window length and zero window count
    drain();
    write_reg(CFG_WINDOW_SAMPLES, 16'd0);
    write_reg(CFG_WINDOWS_PER_PHASE, 16'd0);
    send_sample(16'h8000);
    send_sample(16'h8000);

    // shorten window and phase mid-way, then step to a fresh tone-on phase
    drain();
    write_reg(CFG_WINDOW_SAMPLES, 16'd1);
    write_reg(CFG_WINDOWS_PER_PHASE, 16'd1);
    write_reg(CFG_WINDOW_SHIFT, 16'd0);
    do send_sample(16'h0000); while (tone_low || s_cnt != 0 || w_cnt != 0);

    // pass boundary: 21 against 20 passes exactly, 20 against 21 fails
    drain();
    write_reg(CFG_WINDOW_SAMPLES, 16'd3);
    send_sample(16'd4);
    send_sample(16'd2);
    send_sample(16'd1);
    send_sample(16'hFFFC);
    send_sample(16'd2);
    send_sample(16'd0);
    send_sample(16'd4);
    send_sample(16'hFFFE);
    send_sample(16'd0);
    send_sample(16'd4);
    send_sample(16'd2);
    send_sample(16'hFFFF);

    // random phases; the first runs whole channel sequences quickly
    for (int p = 0; p < 9; p++) begin
      drain();
      if (p == 0) begin
        write_reg(CFG_WINDOW_SAMPLES, 16'd1);
        write_reg(CFG_WINDOWS_PER_PHASE, 16'd1);
        write_reg(CFG_WINDOW_SHIFT, 16'd0);
      end else begin
        r = $urandom_range(0, 9);
        write_reg(CFG_WINDOW_SAMPLES,
                  CFG_DATA_W'((r < 7) ? $urandom_range(1, 4) :
                              (r < 9) ? $urandom_range(5, 40) : $urandom_range(41, 300)));
        r = $urandom_range(0, 9);
        write_reg(CFG_WINDOWS_PER_PHASE,
                  CFG_DATA_W'((r < 7) ? $urandom_range(1, 3) : $urandom_range(4, 255)));
        r = $urandom_range(0, 9);
        write_reg(CFG_WINDOW_SHIFT,
                  CFG_DATA_W'((r < 5) ? $urandom_range(0, 12) :
                              (r < 8) ? $urandom_range(13, 40) : $urandom_range(41, 63)));
      end
      steady     = (p != 0) && ($urandom_range(0, 3) == 0);
      n_items    = (p == 0) ? 160 : $urandom_range(30, 70);
      burst_left = (p == 0) ? 64 : 0;
      for (int i = 0; i < n_items; i++) begin
        if (burst_left == 0 && $urandom_range(0, 199) == 0) burst_left = $urandom_range(32, 64);
        if (burst_left > 0) begin
          // full-scale run drives the meter to its top
          burst_left--;
          s = 16'h8000;
        end else if ($urandom_range(0, 9) == 0) begin
          s = 16'($urandom);
        end else begin
          s = draw_sample(tone_low ? amp_lo : amp_hi);
        end
        send_sample(s);
      end
    end

    drain();
    repeat (2 * STAGES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
